// ===== design/lgrs_pkg.sv =====
// Shared types and constants for the Life generation row stream block.
package lgrs_pkg;

  localparam int ROW_BITS      = 64;
  localparam int WIDTH_BITS    = 7;
  localparam int MAX_WIDTH_DEF = 64;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd8;

  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_CNT_BITS = 3;

  typedef struct packed {
    logic [ROW_BITS-1:0] cells;
    logic                is_last;
    logic                edge_alive;
  } result_t;

endpackage

// ===== design/lgrs_cell_lane.sv =====
// One cell lane: neighbor count and the B3/S23 rule.
module lgrs_cell_lane (
  input  logic [7:0] nbr,
  input  logic       self_alive,
  output logic       alive_next
);

  logic [3:0] n;

  always_comb begin
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, nbr[k]};
    end
  end

  assign alive_next = self_alive ? ((n == lgrs_pkg::SURVIVE_LOW) || (n == lgrs_pkg::SURVIVE_HIGH))
                                 : (n == lgrs_pkg::BIRTH_COUNT);

endmodule

// ===== design/lgrs_row_evolve.sv =====
// Row of parallel cell lanes computing the next generation of the middle row.
module lgrs_row_evolve #(
  parameter int MAX_WIDTH = lgrs_pkg::MAX_WIDTH_DEF
) (
  input  logic [MAX_WIDTH-1:0] up,
  input  logic [MAX_WIDTH-1:0] mid,
  input  logic [MAX_WIDTH-1:0] down,
  input  logic [MAX_WIDTH-1:0] mask,
  output logic [MAX_WIDTH-1:0] nxt
);

  logic [MAX_WIDTH+1:0] pad_up;
  logic [MAX_WIDTH+1:0] pad_mid;
  logic [MAX_WIDTH+1:0] pad_down;

  assign pad_up   = {1'b0, up, 1'b0};
  assign pad_mid  = {1'b0, mid, 1'b0};
  assign pad_down = {1'b0, down, 1'b0};

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_lane
    logic alive;
    lgrs_cell_lane u_lane (
      .nbr        ({pad_up[i+2:i], pad_mid[i+2], pad_mid[i], pad_down[i+2:i]}),
      .self_alive (mid[i]),
      .alive_next (alive)
    );
    assign nxt[i] = alive & mask[i];
  end

endmodule

// ===== design/lgrs_out_fifo.sv =====
// Result queue taking up to two transactions per cycle and draining one per cycle while the receiver is ready.
module lgrs_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  lgrs_pkg::result_t   wr0,
  input  lgrs_pkg::result_t   wr1,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output lgrs_pkg::result_t   out_data
);

  lgrs_pkg::result_t                     mem [lgrs_pkg::FIFO_DEPTH];
  logic [lgrs_pkg::FIFO_PTR_BITS-1:0]    wptr;
  logic [lgrs_pkg::FIFO_PTR_BITS-1:0]    rptr;
  logic [lgrs_pkg::FIFO_CNT_BITS-1:0]    count;
  logic [lgrs_pkg::FIFO_CNT_BITS-1:0]    count_next;
  logic                                  pop;

  assign out_valid  = (count != '0);
  assign out_data   = mem[rptr];
  assign pop        = out_valid & out_ready;
  assign room       = (count <= lgrs_pkg::FIFO_CNT_BITS'(lgrs_pkg::FIFO_DEPTH - 2));
  assign count_next = count + lgrs_pkg::FIFO_CNT_BITS'(push_n)
                            - lgrs_pkg::FIFO_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + lgrs_pkg::FIFO_PTR_BITS'(push_n);
      rptr  <= rptr + lgrs_pkg::FIFO_PTR_BITS'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr] <= wr0;
    end
    if (push_n == 2'd2) begin
      mem[wptr + lgrs_pkg::FIFO_PTR_BITS'(1)] <= wr1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= lgrs_pkg::FIFO_CNT_BITS'(lgrs_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

// ===== design/life_generation_row_stream.sv =====
// Top level: streaming one-generation Life engine over a bounded board.
//
// Input channel s_axis carries one board row per transaction, top to bottom:
// tdata bit i is column i, tuser marks the top row, tlast the bottom row.
// Output channel m_axis carries rows of the next generation: tdata is the
// row, tlast marks its bottom row, tuser flags a live border cell (bottom
// row only). Each row after the top emits the new row above it; the bottom
// row emits one more, so a board of N rows yields N results.
// cfg_wr_en/cfg_wr_data set the board width (columns in use); write it only
// while the block is idle.
// Throughput: one input row per cycle while s_axis_tready is high; the bottom
// row yields two results, which the single-result output port sends one at a
// time. Results are written into the result queue when the row that causes
// them is taken, and m_axis presents them from the queue in order.
// A four-entry result queue separates the channels: s_axis_tready stays high
// while the queue has room for two results, so a stalled receiver stops
// input once fewer than two entries are free.
// Reset clears the held rows, the queue and sets the width to 8.
module life_generation_row_stream #(
  parameter int MAX_WIDTH = lgrs_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [lgrs_pkg::WIDTH_BITS-1:0]    cfg_wr_data,   // board_width
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lgrs_pkg::ROW_BITS-1:0]      s_axis_tdata,  // row_cells
  input  logic                               s_axis_tuser,  // first_row
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lgrs_pkg::ROW_BITS-1:0]      m_axis_tdata,  // next_row_cells
  output logic                               m_axis_tuser,  // edge_alive
  output logic                               m_axis_tlast
);

  localparam int WB = lgrs_pkg::WIDTH_BITS;

  logic [WB-1:0]        board_width;
  logic [MAX_WIDTH-1:0] row_above;
  logic [MAX_WIDTH-1:0] row_middle;
  logic                 have_middle;
  logic                 middle_is_top;
  logic                 edge_seen;

  logic [MAX_WIDTH-1:0] row_above_next;
  logic [MAX_WIDTH-1:0] row_middle_next;
  logic                 have_middle_next;
  logic                 middle_is_top_next;
  logic                 edge_seen_next;

  logic [WB-1:0]        used_w;
  logic [MAX_WIDTH-1:0] width_mask;
  logic [MAX_WIDTH-1:0] border;
  logic [MAX_WIDTH-1:0] row_in;
  logic [MAX_WIDTH-1:0] last_up;
  logic [MAX_WIDTH-1:0] nxt_mid;
  logic [MAX_WIDTH-1:0] nxt_last;
  logic                 fire;
  logic                 restart;
  logic                 edge_mid;
  logic                 edge_final;
  logic [1:0]           push_n;
  logic                 room;
  lgrs_pkg::result_t    res_mid;
  lgrs_pkg::result_t    res_last;
  lgrs_pkg::result_t    wr0;
  lgrs_pkg::result_t    out_data;

  assign used_w = (board_width > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : board_width;

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_mask
    assign width_mask[i] = (WB'(i) < used_w);
    assign border[i]     = (used_w != '0) && ((i == 0) || (WB'(i) == used_w - WB'(1)));
  end

  assign s_axis_tready = room;
  assign fire          = s_axis_tvalid & s_axis_tready;
  assign row_in        = s_axis_tdata[MAX_WIDTH-1:0] & width_mask;
  assign restart       = s_axis_tuser | ~have_middle;
  assign last_up       = restart ? '0 : row_middle;

  lgrs_row_evolve #(.MAX_WIDTH(MAX_WIDTH)) u_evolve_mid (
    .up   (row_above),
    .mid  (row_middle),
    .down (row_in),
    .mask (width_mask),
    .nxt  (nxt_mid)
  );

  lgrs_row_evolve #(.MAX_WIDTH(MAX_WIDTH)) u_evolve_last (
    .up   (last_up),
    .mid  (row_in),
    .down ('0),
    .mask (width_mask),
    .nxt  (nxt_last)
  );

  // merge lane results into border flags
  assign edge_mid   = edge_seen | (middle_is_top & (|nxt_mid)) | (|(nxt_mid & border));
  assign edge_final = (restart ? 1'b0 : edge_mid) | (|nxt_last);

  assign res_mid  = '{cells: lgrs_pkg::ROW_BITS'(nxt_mid), is_last: 1'b0, edge_alive: 1'b0};
  assign res_last = '{cells: lgrs_pkg::ROW_BITS'(nxt_last), is_last: 1'b1,
                      edge_alive: edge_final};
  assign wr0      = restart ? res_last : res_mid;
  assign push_n   = fire ? ({1'b0, ~restart} + {1'b0, s_axis_tlast}) : 2'd0;

  always_comb begin
    row_above_next     = row_above;
    row_middle_next    = row_middle;
    have_middle_next   = have_middle;
    middle_is_top_next = middle_is_top;
    edge_seen_next     = edge_seen;
    if (fire) begin
      if (s_axis_tlast) begin
        row_above_next     = '0;
        row_middle_next    = '0;
        have_middle_next   = 1'b0;
        middle_is_top_next = 1'b0;
        edge_seen_next     = 1'b0;
      end else if (restart) begin
        row_above_next     = '0;
        row_middle_next    = row_in;
        have_middle_next   = 1'b1;
        middle_is_top_next = 1'b1;
        edge_seen_next     = 1'b0;
      end else begin
        row_above_next     = row_middle;
        row_middle_next    = row_in;
        middle_is_top_next = 1'b0;
        edge_seen_next     = edge_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      board_width   <= lgrs_pkg::WIDTH_RESET;
      row_above     <= '0;
      row_middle    <= '0;
      have_middle   <= 1'b0;
      middle_is_top <= 1'b0;
      edge_seen     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        board_width <= cfg_wr_data;
      end
      row_above     <= row_above_next;
      row_middle    <= row_middle_next;
      have_middle   <= have_middle_next;
      middle_is_top <= middle_is_top_next;
      edge_seen     <= edge_seen_next;
    end
  end

  lgrs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .wr0       (wr0),
    .wr1       (res_last),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = out_data.cells;
  assign m_axis_tlast = out_data.is_last;
  assign m_axis_tuser = out_data.edge_alive;

  a_edge_only_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("border flag on a result that is not the bottom row");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !have_middle |-> (!middle_is_top && !edge_seen && row_above == '0))
    else $error("stale board state with no pending row");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (fire && s_axis_tlast) |=> !have_middle)
    else $error("bottom row left a board open");

  a_top_opens: assert property (@(posedge clk) disable iff (rst)
    (fire && s_axis_tuser && !s_axis_tlast) |=> (have_middle && middle_is_top))
    else $error("top row did not open a board");

endmodule

// ===== verif/testbench.sv =====
// Testbench for the Life generation row stream block.
module testbench;

  localparam int MAX_COLS = lgrs_pkg::MAX_WIDTH_DEF;
  localparam int DRAIN_LIMIT = 4000;

  logic                            clk;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [lgrs_pkg::WIDTH_BITS-1:0] cfg_wr_data;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [lgrs_pkg::ROW_BITS-1:0]   s_axis_tdata;   // row_cells
  logic                            s_axis_tuser;   // first_row
  logic                            s_axis_tlast;   // last_row
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [lgrs_pkg::ROW_BITS-1:0]   m_axis_tdata;   // next_row_cells
  logic                            m_axis_tuser;   // edge_alive
  logic                            m_axis_tlast;   // row_is_last

  life_generation_row_stream u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [lgrs_pkg::WIDTH_BITS-1:0] width_setting;
  logic [lgrs_pkg::ROW_BITS-1:0]   held_above;
  logic [lgrs_pkg::ROW_BITS-1:0]   held_middle;
  bit                              middle_valid;
  bit                              middle_top;
  bit                              border_live;

  lgrs_pkg::result_t expected_rows[$];
  lgrs_pkg::result_t want;
  int unsigned       mismatch_count;
  int unsigned       rows_sent;
  bit                steady_flow;
  bit                sender_gaps;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned cols_in_use();
    return (int'(width_setting) > MAX_COLS) ? MAX_COLS : int'(width_setting);
  endfunction

  function automatic logic [lgrs_pkg::ROW_BITS-1:0] column_mask();
    if (cols_in_use() >= lgrs_pkg::ROW_BITS) return '1;
    return (64'd1 << cols_in_use()) - 64'd1;
  endfunction

  function automatic logic [lgrs_pkg::ROW_BITS-1:0] border_columns();
    if (cols_in_use() == 0) return '0;
    return 64'd1 | (64'd1 << (cols_in_use() - 1));
  endfunction

  function automatic logic [lgrs_pkg::ROW_BITS-1:0] next_generation(
      input logic [lgrs_pkg::ROW_BITS-1:0] up,
      input logic [lgrs_pkg::ROW_BITS-1:0] mid,
      input logic [lgrs_pkg::ROW_BITS-1:0] down);
    logic [lgrs_pkg::ROW_BITS-1:0] nb [8];
    logic [lgrs_pkg::ROW_BITS-1:0] gen;
    int unsigned                   n;
    nb[0] = up << 1;   nb[1] = up;   nb[2] = up >> 1;
    nb[3] = mid << 1;  nb[4] = mid >> 1;
    nb[5] = down << 1; nb[6] = down; nb[7] = down >> 1;
    gen = '0;
    for (int i = 0; i < lgrs_pkg::ROW_BITS; i++) begin
      n = 0;
      for (int k = 0; k < 8; k++) n += 32'(nb[k][i]);
      if (mid[i] ? (n == lgrs_pkg::SURVIVE_LOW || n == lgrs_pkg::SURVIVE_HIGH)
                 : (n == lgrs_pkg::BIRTH_COUNT)) gen[i] = 1'b1;
    end
    return gen & column_mask();
  endfunction

  task automatic predict_row(input logic [lgrs_pkg::ROW_BITS-1:0] cells, input bit first,
                             input bit last);
    logic [lgrs_pkg::ROW_BITS-1:0] row;
    logic [lgrs_pkg::ROW_BITS-1:0] border;
    lgrs_pkg::result_t             r;
    row = cells & column_mask();
    border = border_columns();
    if (first || !middle_valid) begin
      held_above = '0;
      held_middle = row;
      middle_valid = 1'b1;
      middle_top = 1'b1;
      border_live = 1'b0;
    end else begin
      r.cells = next_generation(held_above, held_middle, row);
      r.is_last = 1'b0;
      r.edge_alive = 1'b0;
      if ((middle_top && r.cells != 0) || (r.cells & border) != 0) border_live = 1'b1;
      expected_rows.push_back(r);
      held_above = held_middle;
      held_middle = row;
      middle_top = 1'b0;
    end
    if (last) begin
      r.cells = next_generation(held_above, held_middle, '0);
      if (r.cells != 0) border_live = 1'b1;
      r.is_last = 1'b1;
      r.edge_alive = border_live;
      expected_rows.push_back(r);
      held_above = '0;
      held_middle = '0;
      middle_valid = 1'b0;
      middle_top = 1'b0;
      border_live = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row %h last %b edge %b",
                                  m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end else begin
        want = expected_rows.pop_front();
        if (m_axis_tdata !== want.cells)
          report_mismatch($sformatf("cells %h, want %h", m_axis_tdata, want.cells));
        if (m_axis_tlast !== want.is_last)
          report_mismatch($sformatf("row_is_last %b, want %b", m_axis_tlast, want.is_last));
        if (m_axis_tuser !== want.edge_alive)
          report_mismatch($sformatf("edge_alive %b, want %b", m_axis_tuser, want.edge_alive));
      end
    end
  end

  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!steady_flow && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 7) == 0) repeat (30) @(negedge clk);
      end
    end
  end

  task automatic send_row(input logic [lgrs_pkg::ROW_BITS-1:0] cells, input bit first,
                          input bit last);
    @(negedge clk);
    if (!steady_flow && sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = {$urandom(), $urandom()};
      s_axis_tuser = 1'($urandom_range(0, 1));
      s_axis_tlast = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tdata = cells;
    s_axis_tuser = first;
    s_axis_tlast = last;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_row(cells, first, last);
    rows_sent++;
  endtask

  // hold input idle until every expected row has come back or DRAIN_LIMIT runs out
  task automatic wait_drained();
    int unsigned waited;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    waited = 0;
    while (expected_rows.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_rows.size() != 0) begin
      report_mismatch($sformatf("%0d rows never arrived", expected_rows.size()));
      expected_rows.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [lgrs_pkg::WIDTH_BITS-1:0] w);
    wait_drained();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = w;
    width_setting = w;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [lgrs_pkg::ROW_BITS-1:0] random_row();
    logic [lgrs_pkg::ROW_BITS-1:0] a;
    logic [lgrs_pkg::ROW_BITS-1:0] b;
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: return a;
      1: return a & b;
      2: return a | b;
      default: return (64'h7 << $urandom_range(0, 61)) | (a & b & {$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [lgrs_pkg::WIDTH_BITS-1:0] pick_width();
    case ($urandom_range(0, 11))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd127;
      4: return lgrs_pkg::WIDTH_BITS'($urandom_range(65, 126));
      5: return lgrs_pkg::WIDTH_BITS'($urandom_range(2, 8));
      default: return lgrs_pkg::WIDTH_BITS'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic test_small_patterns();
    sender_gaps = 1'b1;
    send_row(64'h00, 1'b1, 1'b0);
    send_row(64'h08, 1'b0, 1'b0);
    send_row(64'h08, 1'b0, 1'b0);
    send_row(64'h08, 1'b0, 1'b0);
    send_row(64'h00, 1'b0, 1'b1);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b0);
    send_row('1, 1'b0, 1'b1);
    send_row(64'h7E, 1'b1, 1'b1);
    send_row(64'h3C, 1'b0, 1'b1);
    send_row(64'h18, 1'b0, 1'b0);
    send_row(64'h18, 1'b0, 1'b1);
    send_row(64'h0F, 1'b1, 1'b0);
    send_row(64'hF0, 1'b0, 1'b0);
    send_row(64'h24, 1'b1, 1'b0);
    send_row(64'h24, 1'b0, 1'b0);
    send_row(64'h24, 1'b0, 1'b1);
  endtask

  task automatic test_width_extremes();
    write_width(7'd1);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);
    write_width(7'd64);
    send_row(64'h8000_0000_0000_0001, 1'b1, 1'b0);
    send_row(64'hC000_0000_0000_0003, 1'b0, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0, 1'b1);
    write_width(7'd127);
    send_row('1, 1'b1, 1'b1);
    write_width(7'd0);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);
    // change width while a row is held
    write_width(7'd16);
    send_row(64'hFFFF_FFFF, 1'b1, 1'b0);
    write_width(7'd8);
    send_row(64'h0000_FFFF, 1'b0, 1'b0);
    send_row(64'h0000_FFFF, 1'b0, 1'b1);
  endtask

  task automatic test_random_boards(input int unsigned count);
    int unsigned start;
    int unsigned boards;
    int unsigned len;
    start = rows_sent;
    boards = 0;
    while (rows_sent - start < count) begin
      if (boards % 12 == 0) write_width(pick_width());
      sender_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 3))
            send_row(random_row(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        1: begin
          send_row(random_row(), 1'b1, 1'b0);
          repeat ($urandom_range(1, 4)) send_row(random_row(), 1'b0, 1'b0);
        end
        default: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
          for (int unsigned r = 0; r < len; r++)
            send_row(random_row(), r == 0, r == len - 1);
        end
      endcase
      boards++;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = lgrs_pkg::WIDTH_RESET;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    width_setting = lgrs_pkg::WIDTH_RESET;
    held_above = '0;
    held_middle = '0;
    middle_valid = 1'b0;
    middle_top = 1'b0;
    border_live = 1'b0;
    mismatch_count = 0;
    rows_sent = 0;
    steady_flow = 1'b0;
    sender_gaps = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_small_patterns();
    test_width_extremes();
    test_random_boards(600);
    wait_drained();
    steady_flow = 1'b1;
    test_random_boards(120);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lgrs_pkg.sv
design/lgrs_cell_lane.sv
design/lgrs_row_evolve.sv
design/lgrs_out_fifo.sv
design/life_generation_row_stream.sv
verif/testbench.sv
